FILE: rtl/motor_speed_mode_generator_defines.svh
// Assertion macros shared by the motor speed mode generator RTL.
`ifndef MOTOR_SPEED_MODE_GENERATOR_DEFINES_SVH
`define MOTOR_SPEED_MODE_GENERATOR_DEFINES_SVH

`ifndef ASSERT_OFF

// Same-cycle implication checked at every clock edge outside reset.
`define MSMG_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication checked at every clock edge outside reset.
`define MSMG_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define MSMG_ASSERT_IMP(lbl, ante, cons, msg)
`define MSMG_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

FILE: rtl/msmg_pkg.sv
// Types, constants and pattern tables for the motor speed mode generator.
`default_nettype none

package msmg_pkg;

	// Fixed-point format of all speeds.
	localparam int FRAC_BITS = 8;
	localparam int SCALE     = 1 << FRAC_BITS;
	localparam int SPD_W     = 8 + FRAC_BITS;

	// Shared multiplier and divider widths.
	localparam int XW      = (FRAC_BITS + 1 > 16) ? FRAC_BITS + 1 : 16;
	localparam int MUL_W   = (SPD_W > 16) ? SPD_W : 16;
	localparam int PROD_W  = XW + MUL_W;
	localparam int DIV_W   = 16;
	localparam int CNT_W   = $clog2(PROD_W);
	localparam int RES_W   = PROD_W + 3;
	localparam int SAT_HI  = (255 * SCALE > 'hFFFF) ? 'hFFFF : 255 * SCALE;
	localparam int BASE_HI = 'hFFFF;

	// Pattern tables.
	localparam int MAX_PATTERN_STEPS = 6;
	localparam int IDX_W    = $clog2(MAX_PATTERN_STEPS);
	localparam int LEN_W    = $clog2(MAX_PATTERN_STEPS + 1);
	localparam int WAVE_LEN = 4;
	localparam int STEP_LEN = 6;
	localparam int WAVE_IW  = $clog2(WAVE_LEN);
	localparam int STEP_IW  = $clog2(STEP_LEN);

	// Configuration port.
	localparam int ADDR_W = 5;

	localparam logic [2:0] REG_MODE        = 3'd0;
	localparam logic [2:0] REG_START_SPEED = 3'd1;
	localparam logic [2:0] REG_MAX_SPEED   = 3'd2;
	localparam logic [2:0] REG_RAMP_TICKS  = 3'd3;
	localparam logic [2:0] REG_EDGE_DELAY  = 3'd4;
	localparam logic [2:0] REG_SENSITIVITY = 3'd5;
	localparam logic [2:0] REG_PAT_SELECT  = 3'd6;

	// Command codes carried by each request.
	localparam logic [1:0] FUNC_START = 2'd0;
	localparam logic [1:0] FUNC_TICK  = 2'd1;
	localparam logic [1:0] FUNC_STOP  = 2'd2;

	typedef enum logic [1:0] {
		MODE_RAMP = 2'd0,
		MODE_ENH  = 2'd1,
		MODE_DEPL = 2'd2,
		MODE_PAT  = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_A,
		ST_DIV,
		ST_POST_A,
		ST_MUL_B,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic [7:0] level;
		logic [7:0] hold;
		logic       ramp;
	} pat_entry_t;

	localparam pat_entry_t STEP_TAB [STEP_LEN] = '{
		'{8'd0,   8'd60, 1'b0},
		'{8'd64,  8'd60, 1'b0},
		'{8'd128, 8'd60, 1'b0},
		'{8'd194, 8'd60, 1'b0},
		'{8'd255, 8'd60, 1'b0},
		'{8'd255, 8'd60, 1'b1}
	};

	localparam pat_entry_t WAVE_TAB [WAVE_LEN] = '{
		'{8'd64,  8'd60, 1'b1},
		'{8'd255, 8'd30, 1'b1},
		'{8'd128, 8'd30, 1'b1},
		'{8'd255, 8'd60, 1'b1}
	};

	// Table lookup; an index past the end of the table reads the first entry.
	function automatic pat_entry_t pat_lookup(input logic sel, input logic [IDX_W-1:0] idx);
		pat_entry_t e;
		e = STEP_TAB[0];
		if (sel) begin
			if (int'(idx) < STEP_LEN) begin
				e = STEP_TAB[idx[STEP_IW-1:0]];
			end
		end else begin
			if (int'(idx) < WAVE_LEN) begin
				e = WAVE_TAB[idx[WAVE_IW-1:0]];
			end else begin
				e = WAVE_TAB[0];
			end
		end
		return e;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/motor_speed_mode_generator.sv
// Motor speed mode generator: register file, sequencer and shared multiply/divide unit.
//
// Usage: each request on the input channel (in_valid/in_ready) carries a command
// (func: start, tick or stop), the fed-back motor speed and an arousal reading.
// One result, the next motor speed in unsigned fixed point, leaves on the output
// channel (out_valid/out_ready). Mode and tuning values are written through the
// APB port; the user must do so only while no request is in flight, and the
// block itself does not enforce it; pready is always high. A request runs
// through a multiply step, the shared restoring divider and a finishing step; a
// depletion tick runs a second multiply and divide pass. The block takes a new
// request in the cycle after the result is registered, and not before. The
// divider retires one quotient bit per cycle over a 32-bit dividend, once per
// request and twice for a depletion tick.
// The result sits in an output register; a stalled receiver holds it there and
// the next request finishes into it only once it has been taken.
// Reset loads the default register values, clears the stop flag, base level and
// pattern position, and leaves the block idle and ready.
`default_nettype none
`include "motor_speed_mode_generator_defines.svh"

module motor_speed_mode_generator import msmg_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        func,
	input  logic [15:0]       speed_now,
	input  logic [15:0]       arousal,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [15:0]       speed_next
);

	localparam logic signed [RES_W-1:0] SAT_HI_E  = RES_W'(SAT_HI);
	localparam logic signed [RES_W-1:0] BASE_HI_E = RES_W'(BASE_HI);

	// Configuration registers.
	mode_t       mode_q;
	logic [7:0]  start_q;
	logic [7:0]  max_q;
	logic [15:0] ramp_q;
	logic [15:0] edge_dly_q;
	logic [15:0] sens_q;
	logic        pat_sel_q;

	// Block state.
	logic             stop_q;
	logic [15:0]      base_q;
	logic [IDX_W-1:0] step_idx_q;
	logic [7:0]       hold_q;

	// Sequencer and datapath registers.
	state_t            state_q, state_d;
	logic [1:0]        func_q;
	logic [15:0]       now_q;
	logic [15:0]       ar_q;
	logic [PROD_W-1:0] div_quo_q;
	logic [DIV_W-1:0]  div_rem_q;
	logic [DIV_W-1:0]  divisor_q;
	logic              neg_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              pass_b_q;
	logic              out_valid_q;
	logic [15:0]       speed_next_q;

	// Sequencer strobes.
	logic ld_in, ld_mul, div_step, base_upd, fin_go;

	logic [2:0] cfg_idx;
	logic       cfg_wr;

	assign cfg_idx = paddr[ADDR_W-1:2];
	assign cfg_wr  = psel & penable & pwrite;
	assign pready  = 1'b1;

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_RAMP;
			start_q    <= 8'd0;
			max_q      <= 8'd255;
			ramp_q     <= 16'd1500;
			edge_dly_q <= 16'd500;
			sens_q     <= 16'd600;
			pat_sel_q  <= 1'b0;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_MODE:        mode_q     <= mode_t'(pwdata[1:0]);
				REG_START_SPEED: start_q    <= pwdata[7:0];
				REG_MAX_SPEED:   max_q      <= pwdata[7:0];
				REG_RAMP_TICKS:  ramp_q     <= pwdata[15:0];
				REG_EDGE_DELAY:  edge_dly_q <= pwdata[15:0];
				REG_SENSITIVITY: sens_q     <= pwdata[15:0];
				REG_PAT_SELECT:  pat_sel_q  <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	// Register reads.
	always_comb begin
		prdata = 32'd0;
		case (cfg_idx)
			REG_MODE:        prdata = {30'd0, mode_q};
			REG_START_SPEED: prdata = {24'd0, start_q};
			REG_MAX_SPEED:   prdata = {24'd0, max_q};
			REG_RAMP_TICKS:  prdata = {16'd0, ramp_q};
			REG_EDGE_DELAY:  prdata = {16'd0, edge_dly_q};
			REG_SENSITIVITY: prdata = {16'd0, sens_q};
			REG_PAT_SELECT:  prdata = {31'd0, pat_sel_q};
			default:         prdata = 32'd0;
		endcase
	end

	// Speeds scaled to fixed point and sign-extended for the result arithmetic.
	logic [SPD_W-1:0]        s_val, m_val;
	logic signed [RES_W-1:0] s_e, m_e, now_e, base_e;

	assign s_val  = {start_q, {FRAC_BITS{1'b0}}};
	assign m_val  = {max_q, {FRAC_BITS{1'b0}}};
	assign s_e    = $signed({{(RES_W-SPD_W){1'b0}}, s_val});
	assign m_e    = $signed({{(RES_W-SPD_W){1'b0}}, m_val});
	assign now_e  = $signed({{(RES_W-16){1'b0}}, now_q});
	assign base_e = $signed({{(RES_W-16){1'b0}}, base_q});

	// Pattern position: a start restarts the table, an index past the table wraps to zero.
	logic [LEN_W-1:0] pat_len;
	logic [IDX_W-1:0] idx_eff;
	logic [LEN_W-1:0] idx_inc;
	logic [IDX_W-1:0] idx_nxt;
	logic [7:0]       hold_new;
	pat_entry_t       pat_cur, pat_nx;
	logic             pat_adv;
	logic [8:0]       pat_diff;
	logic [7:0]       pat_abs;

	always_comb begin
		pat_len = pat_sel_q ? LEN_W'(STEP_LEN) : LEN_W'(WAVE_LEN);
		if (func_q == FUNC_START || LEN_W'(step_idx_q) >= pat_len) begin
			idx_eff = '0;
		end else begin
			idx_eff = step_idx_q;
		end
		hold_new = (func_q == FUNC_START) ? 8'd1 : hold_q + 8'd1;
		idx_inc  = LEN_W'(idx_eff) + LEN_W'(1);
		idx_nxt  = (idx_inc == pat_len) ? '0 : idx_inc[IDX_W-1:0];
		pat_cur  = pat_lookup(pat_sel_q, idx_eff);
		pat_nx   = pat_lookup(pat_sel_q, idx_nxt);
		pat_adv  = hold_new > pat_cur.hold;
		pat_diff = {1'b0, pat_nx.level} - {1'b0, pat_cur.level};
		pat_abs  = pat_diff[8] ? 8'(~pat_diff[7:0] + 8'd1) : pat_diff[7:0];
	end

	// Operand selection for the shared multiplier and divider.
	logic [8:0]        rng_diff;
	logic [7:0]        rng_abs;
	logic [DIV_W-1:0]  ramp_d, edge_d, sens_d;
	logic [XW-1:0]     mul_x;
	logic [MUL_W-1:0]  mul_y;
	logic [DIV_W-1:0]  mul_d;
	logic              mul_neg;
	logic [PROD_W-1:0] mul_p;

	assign rng_diff = {1'b0, max_q} - {1'b0, start_q};
	assign rng_abs  = rng_diff[8] ? 8'(~rng_diff[7:0] + 8'd1) : rng_diff[7:0];
	assign ramp_d   = (ramp_q == '0) ? DIV_W'(1) : ramp_q;
	assign edge_d   = (edge_dly_q == '0) ? DIV_W'(1) : edge_dly_q;
	assign sens_d   = (sens_q == '0) ? DIV_W'(1) : sens_q;

	always_comb begin
		mul_x   = XW'(SCALE);
		mul_y   = '0;
		mul_d   = DIV_W'(1);
		mul_neg = 1'b0;
		if (state_q == ST_MUL_B) begin
			// Depletion reduction: base times arousal over sensitivity.
			mul_x = XW'(ar_q);
			mul_y = MUL_W'(base_q);
			mul_d = sens_d;
		end else if (mode_q == MODE_PAT) begin
			// Pattern ramp towards the next level over the hold time.
			mul_y   = MUL_W'(pat_abs);
			mul_neg = pat_diff[8];
			mul_d   = {{(DIV_W-8){1'b0}}, pat_cur.hold};
		end else if (func_q == FUNC_TICK) begin
			case (mode_q)
				MODE_RAMP, MODE_DEPL: begin
					mul_y   = MUL_W'(rng_abs);
					mul_neg = rng_diff[8];
					mul_d   = ramp_d;
				end
				MODE_ENH: begin
					if (stop_q) begin
						mul_y   = MUL_W'(max_q);
						mul_neg = 1'b1;
						mul_d   = edge_d;
					end else begin
						mul_x   = XW'(ar_q);
						mul_y   = MUL_W'({rng_abs, {FRAC_BITS{1'b0}}});
						mul_neg = rng_diff[8];
						mul_d   = sens_d;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Full-width product of the selected operands.
	assign mul_p = mul_x * mul_y;

	// One restoring divide step per cycle.
	logic [DIV_W:0]   rem_sh, rem_diff;
	logic             rem_ge;
	logic [DIV_W-1:0] rem_nx;
	logic             div_last;

	assign rem_sh   = {div_rem_q, div_quo_q[PROD_W-1]};
	assign rem_ge   = rem_sh >= {1'b0, divisor_q};
	assign rem_diff = rem_sh - {1'b0, divisor_q};
	assign rem_nx   = rem_ge ? rem_diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
	assign div_last = cnt_q == CNT_W'(PROD_W - 1);

	// Signed quotient, truncated toward zero.
	logic signed [RES_W-1:0] q_e, qs;

	assign q_e = $signed({{(RES_W-PROD_W){1'b0}}, div_quo_q});
	assign qs  = neg_q ? -q_e : q_e;

	// Depletion base level after one ramp increment, saturated to 16 bits.
	logic signed [RES_W-1:0] b_sum;
	logic [15:0]             b_new;

	always_comb begin
		b_sum = base_e + qs;
		if (base_e >= m_e) begin
			b_new = base_q;
		end else if (b_sum < 0) begin
			b_new = 16'd0;
		end else if (b_sum > BASE_HI_E) begin
			b_new = 16'hFFFF;
		end else begin
			b_new = b_sum[15:0];
		end
	end

	// Result selection and output saturation.
	logic signed [RES_W-1:0] pat_r, depl_f, res_r;
	logic [15:0]             res_sat;

	always_comb begin
		if (pat_adv) begin
			pat_r = $signed({{(RES_W-SPD_W){1'b0}}, pat_nx.level, {FRAC_BITS{1'b0}}});
		end else if (pat_cur.ramp) begin
			pat_r = now_e + qs;
		end else begin
			pat_r = $signed({{(RES_W-SPD_W){1'b0}}, pat_cur.level, {FRAC_BITS{1'b0}}});
		end
		depl_f = base_e - qs;
		res_r  = now_e;
		case (func_q)
			FUNC_START: res_r = (mode_q == MODE_PAT) ? pat_r : s_e;
			FUNC_STOP:  res_r = (mode_q == MODE_ENH) ? m_e : '0;
			FUNC_TICK: begin
				case (mode_q)
					MODE_RAMP: res_r = (now_e < m_e - qs) ? now_e + qs : m_e;
					MODE_ENH: begin
						if (!stop_q) begin
							res_r = s_e + qs;
						end else if (edge_dly_q != '0) begin
							res_r = now_e + qs;
						end else begin
							res_r = now_e;
						end
					end
					MODE_DEPL: begin
						if (depl_f < s_e) begin
							res_r = s_e;
						end else if (depl_f > m_e) begin
							res_r = m_e;
						end else begin
							res_r = depl_f;
						end
					end
					default: res_r = pat_r;
				endcase
			end
			default: res_r = now_e;
		endcase
		if (res_r < 0) begin
			res_sat = 16'd0;
		end else if (res_r > SAT_HI_E) begin
			res_sat = 16'(SAT_HI);
		end else begin
			res_sat = res_r[15:0];
		end
	end

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer next state and strobes.
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		ld_in    = 1'b0;
		ld_mul   = 1'b0;
		div_step = 1'b0;
		base_upd = 1'b0;
		fin_go   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ld_in   = 1'b1;
					state_d = ST_MUL_A;
				end
			end
			ST_MUL_A: begin
				ld_mul  = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				div_step = 1'b1;
				if (div_last) begin
					if (!pass_b_q && func_q == FUNC_TICK && mode_q == MODE_DEPL) begin
						state_d = ST_POST_A;
					end else begin
						state_d = ST_FIN;
					end
				end
			end
			ST_POST_A: begin
				base_upd = 1'b1;
				state_d  = ST_MUL_B;
			end
			ST_MUL_B: begin
				ld_mul  = 1'b1;
				state_d = ST_DIV;
			end
			ST_FIN: begin
				if (!out_valid_q || out_ready) begin
					fin_go  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Request capture, multiplier and divider datapath.
	always_ff @(posedge clk) begin
		if (ld_in) begin
			func_q <= func;
			now_q  <= speed_now;
			ar_q   <= arousal;
		end
		if (ld_mul) begin
			div_quo_q <= mul_p;
			div_rem_q <= '0;
			divisor_q <= mul_d;
			neg_q     <= mul_neg;
			cnt_q     <= '0;
			pass_b_q  <= state_q == ST_MUL_B;
		end else if (div_step) begin
			div_quo_q <= {div_quo_q[PROD_W-2:0], rem_ge};
			div_rem_q <= rem_nx;
			cnt_q     <= cnt_q + CNT_W'(1);
		end
		if (fin_go) begin
			speed_next_q <= res_sat;
		end
	end

	// Stop flag, base level, pattern position and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stop_q      <= 1'b0;
			base_q      <= 16'd0;
			step_idx_q  <= '0;
			hold_q      <= 8'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (base_upd) begin
				base_q <= b_new;
			end
			if (fin_go) begin
				out_valid_q <= 1'b1;
				if (mode_q == MODE_PAT && (func_q == FUNC_START || func_q == FUNC_TICK)) begin
					if (pat_adv) begin
						step_idx_q <= idx_nxt;
						hold_q     <= 8'd0;
					end else begin
						step_idx_q <= idx_eff;
						hold_q     <= hold_new;
					end
				end
				if (mode_q == MODE_ENH && func_q == FUNC_START) begin
					stop_q <= 1'b0;
				end
				if (mode_q == MODE_ENH && func_q == FUNC_STOP) begin
					stop_q <= 1'b1;
				end
				if (mode_q == MODE_DEPL && func_q == FUNC_START) begin
					base_q <= 16'(s_val);
				end
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign speed_next = speed_next_q;

	// The divider never runs with a zero divisor.
	`MSMG_ASSERT_IMP(a_div_nonzero, state_q == ST_DIV, divisor_q != '0, "divide by zero")

	// A request keeps the block busy in the following cycle.
	`MSMG_ASSERT_NXT(a_busy_after_req, in_valid && in_ready, !in_ready, "ready after request")

	// A result appears only out of the finishing step.
	`MSMG_ASSERT_IMP(a_out_from_fin, $rose(out_valid_q), $past(state_q == ST_FIN), "stray result")

	// The pattern position never passes the longest table.
	`MSMG_ASSERT_IMP(a_idx_range, 1'b1, int'(step_idx_q) < STEP_LEN, "step index out of range")

endmodule

`default_nettype wire

FILE: bench/speed_checker.sv
// Checker for the motor speed mode generator: tracks register writes, predicts each speed and compares.
module speed_checker import msmg_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	input  logic              pready,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic [1:0]        func,
	input  logic [15:0]       speed_now,
	input  logic [15:0]       arousal,
	input  logic              out_valid,
	input  logic              out_ready,
	input  logic [15:0]       speed_next,
	output int                mismatches,
	output int                pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint UNIT    = longint'(1) << FRAC_BITS;
	localparam longint OUT_TOP = (255 * UNIT > 65535) ? 65535 : 255 * UNIT;

	// One entry of a speed pattern: level, ticks to hold it, and whether to slope to the next.
	typedef struct packed {
		logic [7:0] level;
		logic [7:0] hold;
		logic       slope;
	} stage_t;

	// Register copies.
	mode_t       run_mode;
	logic [7:0]  start_spd;
	logic [7:0]  max_spd;
	logic [15:0] ramp_len;
	logic [15:0] edge_len;
	logic [15:0] sens_reg;
	logic        use_steps;

	// Block state as the block should hold it.
	logic        stopped;
	logic [15:0] base_lvl;
	logic [2:0]  step_idx;
	logic [7:0]  hold_cnt;

	logic [15:0] expected_speeds[$];
	logic [15:0] want;

	function automatic stage_t stage_at(logic steps, int idx);
		stage_t s;
		if (steps) begin
			case (idx)
				1: s = '{8'd64, 8'd60, 1'b0};
				2: s = '{8'd128, 8'd60, 1'b0};
				3: s = '{8'd194, 8'd60, 1'b0};
				4: s = '{8'd255, 8'd60, 1'b0};
				5: s = '{8'd255, 8'd60, 1'b1};
				default: s = '{8'd0, 8'd60, 1'b0};
			endcase
		end else begin
			case (idx)
				1: s = '{8'd255, 8'd30, 1'b1};
				2: s = '{8'd128, 8'd30, 1'b1};
				3: s = '{8'd255, 8'd60, 1'b1};
				default: s = '{8'd64, 8'd60, 1'b1};
			endcase
		end
		return s;
	endfunction

	// Per-tick increment of a ramp; a zero tick count counts as one.
	function automatic longint ramp_step(longint from_lvl, longint to_lvl, longint ticks);
		return ((to_lvl - from_lvl) * UNIT) / ((ticks == 0) ? 1 : ticks);
	endfunction

	function automatic logic [15:0] clamp_speed(longint v);
		if (v < 0) return 16'd0;
		if (v > OUT_TOP) return 16'(OUT_TOP);
		return v[15:0];
	endfunction

	// One tick of the pattern sequencer.
	function automatic longint pattern_advance(longint now_v);
		int len;
		stage_t cur;
		stage_t nxt;
		len = use_steps ? 6 : 4;
		if (step_idx >= len) step_idx = 3'd0;
		hold_cnt = hold_cnt + 8'd1;
		cur = stage_at(use_steps, step_idx);
		if (hold_cnt > cur.hold) begin
			step_idx = 3'((int'(step_idx) + 1) % len);
			hold_cnt = 8'd0;
			nxt = stage_at(use_steps, step_idx);
			return longint'(nxt.level) * UNIT;
		end
		nxt = stage_at(use_steps, (int'(step_idx) + 1) % len);
		if (cur.slope) return now_v + ramp_step(cur.level, nxt.level, cur.hold);
		return longint'(cur.level) * UNIT;
	endfunction

	// Next speed for one request; updates the tracked state.
	function automatic logic [15:0] next_speed(logic [1:0] cmd, logic [15:0] now_in,
			logic [15:0] ar_in);
		longint now_v, ar_v, lo, hi, sens, r, b, f, inc;
		now_v = now_in;
		ar_v = ar_in;
		lo = longint'(start_spd) * UNIT;
		hi = longint'(max_spd) * UNIT;
		sens = (sens_reg == 16'd0) ? 1 : sens_reg;
		r = now_v;
		case (cmd)
			FUNC_START: begin
				r = lo;
				if (run_mode == MODE_ENH) begin
					stopped = 1'b0;
				end else if (run_mode == MODE_DEPL) begin
					base_lvl = clamp_speed(lo);
				end else if (run_mode == MODE_PAT) begin
					step_idx = 3'd0;
					hold_cnt = 8'd0;
					r = pattern_advance(now_v);
				end
			end
			FUNC_STOP: begin
				r = 0;
				if (run_mode == MODE_ENH) begin
					stopped = 1'b1;
					r = hi;
				end
			end
			FUNC_TICK: begin
				case (run_mode)
					MODE_RAMP: begin
						inc = ramp_step(start_spd, max_spd, ramp_len);
						r = (now_v < hi - inc) ? now_v + inc : hi;
					end
					MODE_ENH: begin
						if (stopped)
							r = (edge_len != 16'd0) ? now_v + ramp_step(max_spd, 0, edge_len) : now_v;
						else
							r = lo + (ar_v * (hi - lo)) / sens;
					end
					MODE_DEPL: begin
						b = base_lvl;
						if (b < hi) begin
							b = b + ramp_step(start_spd, max_spd, ramp_len);
							if (b < 0) b = 0;
							if (b > 65535) b = 65535;
							base_lvl = b[15:0];
						end
						f = b - (b * ar_v) / sens;
						if (f < lo) r = lo;
						else if (f > hi) r = hi;
						else r = f;
					end
					default: begin
						r = pattern_advance(now_v);
					end
				endcase
			end
			default: begin
				// The unused command leaves everything alone and echoes the speed.
			end
		endcase
		return clamp_speed(r);
	endfunction

	// Results are checked before a request of the same edge is predicted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_mode = MODE_RAMP;
			start_spd = 8'd0;
			max_spd = 8'd255;
			ramp_len = 16'd1500;
			edge_len = 16'd500;
			sens_reg = 16'd600;
			use_steps = 1'b0;
			stopped = 1'b0;
			base_lvl = 16'd0;
			step_idx = 3'd0;
			hold_cnt = 8'd0;
			expected_speeds.delete();
			mismatches = 0;
			pending = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_speeds.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result, expected none, got speed_next %h",
						$time, speed_next);
				end else begin
					want = expected_speeds.pop_front();
					if (speed_next !== want) begin
						mismatches++;
						$display("%0t: speed_next mismatch, expected %h, got %h",
							$time, want, speed_next);
					end
				end
			end
			if (psel && penable && pwrite && pready) begin
				case (paddr[ADDR_W-1:2])
					REG_MODE:        run_mode = mode_t'(pwdata[1:0]);
					REG_START_SPEED: start_spd = pwdata[7:0];
					REG_MAX_SPEED:   max_spd = pwdata[7:0];
					REG_RAMP_TICKS:  ramp_len = pwdata[15:0];
					REG_EDGE_DELAY:  edge_len = pwdata[15:0];
					REG_SENSITIVITY: sens_reg = pwdata[15:0];
					REG_PAT_SELECT:  use_steps = pwdata[0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				expected_speeds.push_back(next_speed(func, speed_now, arousal));
			pending = expected_speeds.size();
		end
	end

endmodule

FILE: bench/testbench.sv
// Top of the motor speed mode generator bench: clock, reset, stimulus and verdict.
module testbench import msmg_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam int ITEM_TARGET = 1550;
	localparam int QUIET_LIMIT = 5000;

	// Receiver stall styles.
	typedef enum logic [1:0] {
		DRAIN_FREE,
		DRAIN_COIN,
		DRAIN_SPARSE,
		DRAIN_BLOCKS
	} drain_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;
	logic              in_valid;
	logic              in_ready;
	logic [1:0]        func;
	logic [15:0]       speed_now;
	logic [15:0]       arousal;
	logic              out_valid;
	logic              out_ready;
	logic [15:0]       speed_next;

	int          mismatches;
	int          pending;
	int          sent = 0;
	int          done = 0;
	int          burst_left = 0;
	int          quiet = 0;
	int          sens_now = 600;
	logic [15:0] last_speed = 16'd0;
	drain_t      drain_style;
	int          style_age;
	int          stall_left;

	motor_speed_mode_generator uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready),
		.func(func), .speed_now(speed_now), .arousal(arousal),
		.out_valid(out_valid), .out_ready(out_ready), .speed_next(speed_next)
	);

	speed_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready),
		.func(func), .speed_now(speed_now), .arousal(arousal),
		.out_valid(out_valid), .out_ready(out_ready), .speed_next(speed_next),
		.mismatches(mismatches), .pending(pending)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Count delivered results and keep the last one as motor speed feedback.
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			done <= done + 1;
			last_speed <= speed_next;
		end
	end

	// Receiver stalls; the style is redrawn at random each time its age counter runs out.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			drain_style <= DRAIN_FREE;
			style_age <= 0;
			stall_left <= 0;
		end else begin
			if (style_age == 300) begin
				style_age <= 0;
				drain_style <= drain_t'($urandom_range(0, 3));
			end else begin
				style_age <= style_age + 1;
			end
			case (drain_style)
				DRAIN_FREE:   out_ready <= 1'b1;
				DRAIN_COIN:   out_ready <= 1'($urandom_range(0, 1));
				DRAIN_SPARSE: out_ready <= ($urandom_range(0, 7) == 0);
				default: begin
					if (stall_left > 0) begin
						out_ready <= 1'b0;
						stall_left <= stall_left - 1;
					end else begin
						out_ready <= 1'b1;
						stall_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(10, 60) : 0;
					end
				end
			endcase
		end
	end

	// Watchdog on cycles without any handshake or register access.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || psel) begin
				quiet <= 0;
			end else if (quiet == QUIET_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end else begin
				quiet <= quiet + 1;
			end
		end
	end

	// One request: a sender gap may open at the start of a burst.
	task automatic send_request(input logic [1:0] cmd, input logic [15:0] spd,
			input logic [15:0] ar);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 80);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		func <= cmd;
		speed_now <= spd;
		arousal <= ar;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sent++;
	endtask

	// Stop sending and wait for every outstanding result.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (done != sent) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Register write: setup phase, access phase, then an idle phase.
	task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'({idx, 2'b00});
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		if (idx == REG_SENSITIVITY) sens_now = val[15:0];
	endtask

	function automatic logic [15:0] pick_speed();
		case ($urandom_range(0, 19))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'hFF00;
			3, 4, 5, 6: return 16'($urandom);
			default: return last_speed;
		endcase
	endfunction

	function automatic logic [15:0] pick_arousal();
		int v;
		case ($urandom_range(0, 9))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2, 3: return 16'($urandom);
			default: begin
				v = $urandom_range(0, 2 * sens_now + 1);
				return (v > 65535) ? 16'hFFFF : 16'(v);
			end
		endcase
	endfunction

	function automatic logic [31:0] pick_level();
		case ($urandom_range(0, 5))
			0: return 32'd0;
			1: return 32'd255;
			default: return $urandom_range(0, 255);
		endcase
	endfunction

	function automatic logic [31:0] pick_count(input int typ_hi);
		case ($urandom_range(0, 9))
			0: return 32'd0;
			1: return 32'd1;
			2: return 32'd65535;
			default: return $urandom_range(1, typ_hi);
		endcase
	endfunction

	task automatic run_ticks(input int n);
		int k;
		for (k = 0; k < n; k++) send_request(FUNC_TICK, pick_speed(), pick_arousal());
	endtask

	initial begin
		int len;
		int stop_at;
		int k;
		logic [1:0] cmd;

		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		in_valid <= 1'b0;
		func <= FUNC_START;
		speed_now <= 16'd0;
		arousal <= 16'd0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Ramp-stop with reset settings, including the unused command.
		send_request(FUNC_START, 16'h0000, 16'h0000);
		send_request(FUNC_TICK, 16'h0000, 16'h0000);
		send_request(FUNC_TICK, 16'hFFFF, 16'hFFFF);
		send_request(FUNC_STOP, 16'h1234, 16'h0000);
		send_request(FUNC_UNUSED, 16'hFFFF, 16'hFFFF);
		settle();

		// Enhancement: arousal extremes, then stop and ramp down.
		reg_write(REG_MODE, 32'(MODE_ENH));
		reg_write(REG_START_SPEED, 32'd10);
		reg_write(REG_MAX_SPEED, 32'd200);
		send_request(FUNC_START, 16'h0000, 16'h0000);
		send_request(FUNC_TICK, 16'h0A00, 16'h0000);
		send_request(FUNC_TICK, 16'h0A00, 16'hFFFF);
		send_request(FUNC_TICK, 16'h0A00, 16'd600);
		send_request(FUNC_STOP, 16'h8000, 16'h0000);
		send_request(FUNC_TICK, 16'hC800, 16'h0000);
		settle();

		// A zero edge delay holds the speed after a stop.
		reg_write(REG_EDGE_DELAY, 32'd0);
		send_request(FUNC_TICK, 16'h1234, 16'h0000);
		settle();

		// Depletion with zero ramp ticks and zero sensitivity, then start above max.
		reg_write(REG_MODE, 32'(MODE_DEPL));
		reg_write(REG_RAMP_TICKS, 32'd0);
		reg_write(REG_SENSITIVITY, 32'd0);
		send_request(FUNC_START, 16'h0000, 16'h0000);
		send_request(FUNC_TICK, 16'h0000, 16'h0000);
		send_request(FUNC_TICK, 16'h0000, 16'hFFFF);
		settle();
		reg_write(REG_START_SPEED, 32'd200);
		reg_write(REG_MAX_SPEED, 32'd50);
		send_request(FUNC_START, 16'h0000, 16'h0000);
		send_request(FUNC_TICK, 16'h0000, 16'h0001);
		settle();

		// Pattern mode on both tables.
		reg_write(REG_MODE, 32'(MODE_PAT));
		reg_write(REG_PAT_SELECT, 32'd1);
		reg_write(REG_START_SPEED, 32'd0);
		reg_write(REG_MAX_SPEED, 32'd255);
		send_request(FUNC_START, 16'h0000, 16'h0000);
		send_request(FUNC_TICK, 16'h0000, 16'h0000);
		send_request(FUNC_STOP, 16'hFFFF, 16'hFFFF);
		send_request(FUNC_UNUSED, 16'h0000, 16'h0000);
		settle();
		reg_write(REG_PAT_SELECT, 32'd0);
		send_request(FUNC_START, 16'h0000, 16'h0000);
		send_request(FUNC_TICK, 16'hFFFF, 16'h0000);
		settle();

		// Walk the wave table around once, then the step table far enough that
		// switching back to the wave table leaves the step position out of range.
		reg_write(REG_SENSITIVITY, 32'd600);
		send_request(FUNC_START, pick_speed(), pick_arousal());
		run_ticks(200);
		settle();
		reg_write(REG_PAT_SELECT, 32'd1);
		send_request(FUNC_START, pick_speed(), pick_arousal());
		run_ticks(280);
		settle();
		reg_write(REG_PAT_SELECT, 32'd0);
		run_ticks(30);

		// Random phases: new settings, then mostly start, ticks and maybe a stop.
		while (sent < ITEM_TARGET) begin
			settle();
			reg_write(REG_MODE, $urandom_range(0, 3));
			if ($urandom_range(0, 1)) reg_write(REG_START_SPEED, pick_level());
			if ($urandom_range(0, 1)) reg_write(REG_MAX_SPEED, pick_level());
			if ($urandom_range(0, 1)) reg_write(REG_RAMP_TICKS, pick_count(300));
			if ($urandom_range(0, 1)) reg_write(REG_EDGE_DELAY, pick_count(300));
			if ($urandom_range(0, 1)) reg_write(REG_SENSITIVITY, pick_count(2000));
			if ($urandom_range(0, 3) == 0) reg_write(REG_PAT_SELECT, $urandom_range(0, 1));
			len = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 250) : $urandom_range(5, 60);
			stop_at = $urandom_range(0, 1) ? $urandom_range(1, len) : -1;
			for (k = 0; k < len; k++) begin
				if ($urandom_range(0, 19) == 0) begin
					// Noise request with any command and any payload.
					send_request(2'($urandom_range(0, 3)), 16'($urandom), 16'($urandom));
				end else begin
					if (k == 0 && $urandom_range(0, 4) != 0) cmd = FUNC_START;
					else if (k == stop_at) cmd = FUNC_STOP;
					else cmd = FUNC_TICK;
					send_request(cmd, pick_speed(), pick_arousal());
				end
				if ($urandom_range(0, 99) == 0) settle();
			end
		end

		settle();
		repeat (100) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

FILE: files.f
+incdir+rtl
rtl/msmg_pkg.sv
rtl/motor_speed_mode_generator.sv
bench/speed_checker.sv
bench/testbench.sv
